[sv/gra_pkg.sv]
// shared constants and types for the graph reachability block
`timescale 1ns / 1ps
package gra_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int MAX_EDGES   = 4096;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int COUNT_W     = NODE_W + 1;
   localparam int EDGE_ADDR_W = $clog2(MAX_EDGES);
   localparam int FILL_W      = EDGE_ADDR_W + 1;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // register word index, taken from paddr above the byte offset
   localparam logic REG_NODE_COUNT = 1'b0;

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(1);

   typedef struct packed {
      logic [NODE_W-1:0] src;
      logic [NODE_W-1:0] dst;
   } edge_type;

   typedef struct packed {
      logic               all_reached;
      logic [COUNT_W-1:0] reached_count;
      logic               edge_overflow;
   } result_type;

endpackage

[sv/gra_intf.sv]
// handshake interfaces for the edge/evaluate channel and the result channel
`timescale 1ns / 1ps
interface gra_req_if;
   import gra_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [NODE_W-1:0] source_node;
   logic [NODE_W-1:0] target_node;

   modport source (output valid, action, source_node, target_node, input ready);
   modport sink (input valid, action, source_node, target_node, output ready);
endinterface

interface gra_rsp_if;
   import gra_pkg::*;
   logic               valid;
   logic               ready;
   logic               all_reached;
   logic [COUNT_W-1:0] reached_count;
   logic               edge_overflow;

   modport source (output valid, all_reached, reached_count, edge_overflow, input ready);
   modport sink (input valid, all_reached, reached_count, edge_overflow, output ready);
endinterface

[sv/graph_reachability_all_nodes.sv]
// graph reachability top level: edge loading, walk from node 0, apb config
// add-edge items: one per cycle while idle, stored in the edge ram at the fill index
// evaluate item: the walk rescans the edge ram once per popped node and checks the
//   visited map for each in-range edge that leaves the node; the result is registered
//   in S_DONE once the previous result has been taken
// after each result and after reset a pass clears the visited map,
//   during which no item is taken; reset is synchronous, active high, node_count = 1
`timescale 1ns / 1ps
module graph_reachability_all_nodes (
   input  logic                           clock,
   input  logic                           reset,
   gra_req_if.sink                        req_chan,
   gra_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gra_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gra_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gra_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import gra_pkg::*;

   logic [COUNT_W-1:0] node_count;

   gra_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .node_count (node_count)
   );

   gra_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .node_count (node_count),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan)
   );

endmodule

[sv/gra_ram.sv]
// generic single-write single-read synchronous ram with registered read data
`timescale 1ns / 1ps
module gra_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/gra_csr.sv]
// apb register file holding the node count
`timescale 1ns / 1ps
module gra_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gra_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [gra_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [gra_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic [gra_pkg::COUNT_W-1:0]        node_count
);
   import gra_pkg::*;

   logic [COUNT_W-1:0] node_count_ff;
   logic [COUNT_W-1:0] node_count_in;
   logic               reg_sel;

   assign reg_sel = (paddr[CSR_ADDR_W-1] == REG_NODE_COUNT);

   always_comb begin
      node_count_in = node_count_ff;
      if (psel && penable && pwrite && reg_sel) begin
         node_count_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_sel) begin
         prdata = CSR_DATA_W'(node_count_ff);
      end
   end

   assign pready     = 1'b1;
   assign node_count = node_count_ff;

endmodule

[sv/gra_walk.sv]
// edge store, visited map and pending stack with the walk sequencer
`timescale 1ns / 1ps
module gra_walk (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [gra_pkg::COUNT_W-1:0] node_count,
   gra_req_if.sink                     req_chan,
   gra_rsp_if.source                   rsp_chan
);
   import gra_pkg::*;

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_POP      = 3'd2;
   localparam logic [2:0] S_NODE     = 3'd3;
   localparam logic [2:0] S_EDGE_RD  = 3'd4;
   localparam logic [2:0] S_EDGE_CHK = 3'd5;
   localparam logic [2:0] S_VIS_CHK  = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               overflow_ff, overflow_in;
   logic [NODE_W-1:0]  clr_ff, clr_in;
   logic [COUNT_W-1:0] depth_ff, depth_in;
   logic [COUNT_W-1:0] reached_ff, reached_in;
   logic [FILL_W-1:0]  edge_idx_ff, edge_idx_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [NODE_W-1:0]  dst_ff, dst_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         result_ff, result_in;

   logic [COUNT_W-1:0] limit_now;
   edge_type           req_edge;

   logic                   edge_we, edge_re;
   logic [EDGE_ADDR_W-1:0] edge_waddr, edge_raddr;
   edge_type               edge_rdata;
   logic [2*NODE_W-1:0]    edge_rbits;

   logic              vis_we, vis_re;
   logic [NODE_W-1:0] vis_waddr;
   logic              vis_wdata;
   logic              vis_rdata;

   logic              stk_we, stk_re;
   logic [NODE_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

   assign limit_now = (node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count;
   assign req_edge.src = req_chan.source_node;
   assign req_edge.dst = req_chan.target_node;
   assign edge_rdata   = edge_type'(edge_rbits);

   gra_ram #(.DEPTH(MAX_EDGES), .WIDTH(2*NODE_W)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (req_edge),
      .rd_en   (edge_re),
      .rd_addr (edge_raddr),
      .rd_data (edge_rbits)
   );

   gra_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_visited_ram (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_waddr),
      .wr_data (vis_wdata),
      .rd_en   (vis_re),
      .rd_addr (edge_rdata.dst),
      .rd_data (vis_rdata)
   );

   gra_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      overflow_in  = overflow_ff;
      clr_in       = clr_ff;
      depth_in     = depth_ff;
      reached_in   = reached_ff;
      edge_idx_in  = edge_idx_ff;
      limit_in     = limit_ff;
      node_in      = node_ff;
      dst_in       = dst_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      edge_we    = 1'b0;
      edge_waddr = fill_ff[EDGE_ADDR_W-1:0];
      edge_re    = 1'b0;
      edge_raddr = edge_idx_ff[EDGE_ADDR_W-1:0];
      vis_we     = 1'b0;
      vis_waddr  = clr_ff;
      vis_wdata  = 1'b0;
      vis_re     = 1'b0;
      stk_we     = 1'b0;
      stk_waddr  = depth_ff[NODE_W-1:0];
      stk_wdata  = dst_ff;
      stk_re     = 1'b0;
      stk_raddr  = NODE_W'(depth_ff - COUNT_W'(1));

      req_chan.ready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_CLEAR: begin
            vis_we = 1'b1;
            clr_in = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.action == ACT_EVAL) begin
                  limit_in = limit_now;
                  if (limit_now == '0) begin
                     reached_in = '0;
                     state_in   = S_DONE;
                  end else begin
                     // seed the walk with node 0
                     vis_we     = 1'b1;
                     vis_waddr  = '0;
                     vis_wdata  = 1'b1;
                     stk_we     = 1'b1;
                     stk_waddr  = '0;
                     stk_wdata  = '0;
                     depth_in   = COUNT_W'(1);
                     reached_in = COUNT_W'(1);
                     state_in   = S_POP;
                  end
               end else if ({1'b0, req_chan.target_node} < limit_now) begin
                  if (fill_ff >= FILL_W'(MAX_EDGES)) begin
                     overflow_in = 1'b1;
                  end else begin
                     edge_we = 1'b1;
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end
         end
         S_POP: begin
            if (depth_ff == '0) begin
               state_in = S_DONE;
            end else begin
               stk_re   = 1'b1;
               depth_in = depth_ff - COUNT_W'(1);
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            node_in     = stk_rdata;
            edge_idx_in = '0;
            state_in    = S_EDGE_RD;
         end
         S_EDGE_RD: begin
            if (edge_idx_ff == fill_ff) begin
               state_in = S_POP;
            end else begin
               edge_re  = 1'b1;
               state_in = S_EDGE_CHK;
            end
         end
         S_EDGE_CHK: begin
            // limit can be below an old edge's target, so check it again
            if ((edge_rdata.src == node_ff) && ({1'b0, edge_rdata.dst} < limit_ff)) begin
               vis_re   = 1'b1;
               dst_in   = edge_rdata.dst;
               state_in = S_VIS_CHK;
            end else begin
               edge_idx_in = edge_idx_ff + FILL_W'(1);
               state_in    = S_EDGE_RD;
            end
         end
         S_VIS_CHK: begin
            if (!vis_rdata) begin
               vis_we     = 1'b1;
               vis_waddr  = dst_ff;
               vis_wdata  = 1'b1;
               reached_in = reached_ff + COUNT_W'(1);
               if (depth_ff < COUNT_W'(MAX_NODES)) begin
                  stk_we   = 1'b1;
                  depth_in = depth_ff + COUNT_W'(1);
               end
            end
            edge_idx_in = edge_idx_ff + FILL_W'(1);
            state_in    = S_EDGE_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in            = 1'b1;
               result_in.all_reached   = (reached_ff == limit_ff);
               result_in.reached_count = reached_ff;
               result_in.edge_overflow = overflow_ff;
               fill_in                 = '0;
               overflow_in             = 1'b0;
               clr_in                  = '0;
               state_in                = S_CLEAR;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         fill_ff      <= '0;
         overflow_ff  <= 1'b0;
         clr_ff       <= '0;
         depth_ff     <= '0;
         reached_ff   <= '0;
         edge_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         overflow_ff  <= overflow_in;
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         reached_ff   <= reached_in;
         edge_idx_ff  <= edge_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff  <= limit_in;
      node_ff   <= node_in;
      dst_ff    <= dst_in;
      result_ff <= result_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.all_reached   = result_ff.all_reached;
   assign rsp_chan.reached_count = result_ff.reached_count;
   assign rsp_chan.edge_overflow = result_ff.edge_overflow;

endmodule

[tb/sv/graph_reachability_all_nodes_tb.sv]
// testbench for graph_reachability_all_nodes: directed and random graphs checked by a graph model
`timescale 1ns / 1ps
module graph_reachability_all_nodes_tb;
   import gra_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 11;
   localparam int CLEAR_SETTLE = 1100;   // visited map clearing pass after reset and results
   localparam int CYCLE_LIMIT  = 10_000_000;
   localparam int RANDOM_ITEMS = 2000;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   gra_req_if req_chan ();
   gra_rsp_if rsp_chan ();

   graph_reachability_all_nodes i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // graph model state
   logic [NODE_W-1:0] link_src [MAX_EDGES];
   logic [NODE_W-1:0] link_dst [MAX_EDGES];
   int unsigned       link_fill = 0;
   bit                links_dropped = 1'b0;
   int unsigned       node_count_reg = 1;

   result_type  results_due [$];
   result_type  result_head;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;
   int unsigned counted_items = 0;
   int unsigned req_idle_pct = 24;
   int unsigned rsp_idle_pct = 50;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic int unsigned node_limit();
      return (node_count_reg < MAX_NODES) ? node_count_reg : MAX_NODES;
   endfunction

   function automatic void store_link(input logic [NODE_W-1:0] src,
                                      input logic [NODE_W-1:0] dst);
      if (dst >= node_limit())
         return;
      if (link_fill >= MAX_EDGES) begin
         links_dropped = 1'b1;
         return;
      end
      link_src[link_fill] = src;
      link_dst[link_fill] = dst;
      link_fill++;
   endfunction

   // depth-first walk from node 0, then the graph is cleared
   function automatic result_type evaluate_reachability();
      int unsigned limit;
      int unsigned depth;
      int unsigned reached;
      int unsigned node;
      int unsigned i;
      bit          seen [MAX_NODES];
      int unsigned pending [MAX_NODES];
      result_type  res;
      limit = node_limit();
      depth = 0;
      reached = 0;
      foreach (seen[j])
         seen[j] = 1'b0;
      if (limit != 0) begin
         seen[0] = 1'b1;
         pending[0] = 0;
         depth = 1;
         reached = 1;
         while (depth > 0) begin
            depth--;
            node = pending[depth];
            for (i = 0; i < link_fill; i++) begin
               if (link_src[i] == node && link_dst[i] < limit && !seen[link_dst[i]]) begin
                  seen[link_dst[i]] = 1'b1;
                  reached++;
                  pending[depth] = link_dst[i];
                  depth++;
               end
            end
         end
      end
      res.all_reached   = (reached == limit);
      res.reached_count = COUNT_W'(reached);
      res.edge_overflow = links_dropped;
      link_fill = 0;
      links_dropped = 1'b0;
      return res;
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (results_due.size() == 0) begin
            $error("result item with no evaluate pending");
            failures++;
         end else begin
            result_head = results_due.pop_front();
            if (rsp_chan.all_reached !== result_head.all_reached) begin
               $error("all_reached: expected %0d, got %0d",
                      result_head.all_reached, rsp_chan.all_reached);
               failures++;
            end
            if (rsp_chan.reached_count !== result_head.reached_count) begin
               $error("reached_count: expected %0d, got %0d",
                      result_head.reached_count, rsp_chan.reached_count);
               failures++;
            end
            if (rsp_chan.edge_overflow !== result_head.edge_overflow) begin
               $error("edge_overflow: expected %0d, got %0d",
                      result_head.edge_overflow, rsp_chan.edge_overflow);
               failures++;
            end
         end
      end
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic act, input logic [NODE_W-1:0] src,
                            input logic [NODE_W-1:0] dst);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.action      <= act;
      req_chan.source_node <= src;
      req_chan.target_node <= dst;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      if (act == ACT_EVAL || dst < node_limit())
         counted_items++;
      if (act == ACT_EVAL)
         results_due.push_back(evaluate_reachability());
      else
         store_link(src, dst);
   endtask

   task automatic pause_until_drained(input int unsigned settle);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic is_write, input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {REG_NODE_COUNT, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_node_count();
      logic [CSR_DATA_W-1:0] rdata;
      csr_transfer(1'b0, '0, rdata);
      if (rdata[COUNT_W-1:0] !== COUNT_W'(node_count_reg)) begin
         $error("node_count: expected %0d, got %0d", node_count_reg, rdata[COUNT_W-1:0]);
         failures++;
      end
   endtask

   task automatic write_node_count(input int unsigned value);
      logic [CSR_DATA_W-1:0] rdata;
      pause_until_drained(CLEAR_SETTLE);
      csr_transfer(1'b1, CSR_DATA_W'(value), rdata);
      node_count_reg = value;
      check_node_count();
   endtask

   task automatic test_register_access();
      pause_until_drained(CLEAR_SETTLE);
      check_node_count();
      write_node_count(0);
      write_node_count(MAX_NODES);
      write_node_count(1);
   endtask

   task automatic test_empty_graph();
      write_node_count(0);
      send_item(ACT_ADD, 10'd0, 10'd0);
      send_item(ACT_ADD, 10'd1023, 10'd1023);
      send_item(ACT_EVAL, 10'd0, 10'd0);
      write_node_count(1);
      send_item(ACT_EVAL, 10'd1023, 10'd0);
      // self loop on the only node
      send_item(ACT_ADD, 10'd0, 10'd0);
      send_item(ACT_EVAL, 10'd0, 10'd1023);
   endtask

   task automatic test_out_of_range_links();
      write_node_count(8);
      send_item(ACT_ADD, 10'd0, 10'd1);
      send_item(ACT_ADD, 10'd1, 10'd7);
      send_item(ACT_ADD, 10'd7, 10'd8);
      send_item(ACT_ADD, 10'd1023, 10'd3);
      send_item(ACT_ADD, 10'd0, 10'd1023);
      send_item(ACT_ADD, 10'd3, 10'd4);
      send_item(ACT_EVAL, 10'd1023, 10'd1023);
   endtask

   task automatic test_lowered_count();
      write_node_count(16);
      send_item(ACT_ADD, 10'd0, 10'd12);
      send_item(ACT_ADD, 10'd12, 10'd3);
      send_item(ACT_ADD, 10'd0, 10'd2);
      send_item(ACT_ADD, 10'd2, 10'd9);
      // stored links into node 12 are now past the count
      write_node_count(10);
      send_item(ACT_EVAL, 10'd0, 10'd0);
   endtask

   task automatic test_full_node_range();
      write_node_count(MAX_NODES);
      send_item(ACT_ADD, 10'd0, 10'd1023);
      send_item(ACT_ADD, 10'd1023, 10'd512);
      send_item(ACT_ADD, 10'd512, 10'd1);
      send_item(ACT_ADD, 10'd1, 10'd0);
      send_item(ACT_ADD, 10'd682, 10'd341);
      send_item(ACT_EVAL, 10'd341, 10'd682);
   endtask

   task automatic test_store_overflow();
      int unsigned k;
      write_node_count(MAX_NODES);
      send_item(ACT_ADD, 10'd0, 10'd1);
      send_item(ACT_ADD, 10'd1, 10'd2);
      // filler links from nodes that are never reached
      for (k = 2; k < MAX_EDGES; k++)
         send_item(ACT_ADD, NODE_W'($urandom_range(MAX_NODES - 1, 3)),
                   NODE_W'($urandom_range(MAX_NODES - 1)));
      send_item(ACT_ADD, 10'd0, 10'd5);
      send_item(ACT_ADD, 10'd2, 10'd3);
      send_item(ACT_EVAL, 10'd0, 10'd0);
      // store and flag start clean again
      send_item(ACT_EVAL, 10'd1023, 10'd1023);
   endtask

   task automatic test_random_graphs(input int unsigned item_goal, input int unsigned send_idle,
                                     input int unsigned take_idle);
      int unsigned start;
      int unsigned limit;
      int unsigned size;
      int unsigned style;
      int unsigned pick;
      int unsigned n;
      int unsigned skipped;
      req_idle_pct = send_idle;
      rsp_idle_pct = take_idle;
      start = counted_items;
      while (counted_items - start < item_goal) begin
         if ($urandom_range(1) == 1) begin
            pick = $urandom_range(99);
            if (pick < 5)
               write_node_count(0);
            else if (pick < 10)
               write_node_count(1);
            else if (pick < 15)
               write_node_count(MAX_NODES);
            else if (pick < 25)
               write_node_count($urandom_range(MAX_NODES, 2));
            else
               write_node_count($urandom_range(32, 2));
         end else if ($urandom_range(9) == 0) begin
            pause_until_drained(0);
         end
         limit = node_limit();
         style = $urandom_range(99);
         if (style < 75 && limit >= 2) begin
            // spanning tree over the low nodes, sometimes with one branch cut
            size = $urandom_range((limit < 24) ? limit : 24, 2);
            skipped = ($urandom_range(3) == 0) ? $urandom_range(size - 1, 1) : 0;
            for (n = 1; n < size; n++)
               if (n != skipped)
                  send_item(ACT_ADD, NODE_W'($urandom_range(n - 1)), NODE_W'(n));
            repeat ($urandom_range(4))
               send_item(ACT_ADD, NODE_W'($urandom_range(limit - 1)),
                         NODE_W'($urandom_range(limit - 1)));
         end else if (style < 90) begin
            repeat ($urandom_range(20, 1))
               send_item(ACT_ADD, NODE_W'($urandom), NODE_W'($urandom));
         end
         send_item(ACT_EVAL, NODE_W'($urandom), NODE_W'($urandom));
         if (style >= 90 && $urandom_range(1) == 1)
            send_item(ACT_EVAL, NODE_W'($urandom), NODE_W'($urandom));
      end
   endtask

   initial begin
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.action      <= ACT_ADD;
      req_chan.source_node <= '0;
      req_chan.target_node <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_empty_graph();
      test_out_of_range_links();
      test_lowered_count();
      test_full_node_range();
      test_store_overflow();
      test_random_graphs(RANDOM_ITEMS / 3, 24, 50);
      test_random_graphs(RANDOM_ITEMS / 3, 50, 24);
      test_random_graphs(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);

      pause_until_drained(CLEAR_SETTLE);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
sv/gra_pkg.sv
sv/gra_intf.sv
sv/gra_ram.sv
sv/gra_csr.sv
sv/gra_walk.sv
sv/graph_reachability_all_nodes.sv
tb/sv/graph_reachability_all_nodes_tb.sv
